// File: design/deq_pkg.sv
// Shared constants, request and status codes, and cell control type for the deque core.
`timescale 1ns / 1ps
package deq_pkg;

  // Default number of storage cells.
  localparam int DEPTH_DEFAULT = 64;

  // Payload field widths.
  localparam int WORD_W    = 32;
  localparam int TYPE_W    = 3;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 7;

  // Request codes.
  localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_PEEK_BACK  = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_SEARCH     = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_UPDATE     = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

  // Commands broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic push_front;  // every cell takes its front-side neighbor's word
    logic pop_front;   // every cell takes its back-side neighbor's word
    logic wr_en;       // the addressed cell takes the request word
    logic tap_load;    // tap line copies the words and match flags
    logic tap_shift;   // tap line moves one cell toward the front
  } deq_cell_ctl_t;

endpackage

// File: design/deq_req_if.sv
// Request channel: valid/ready handshake carrying one deque request.
`timescale 1ns / 1ps
interface deq_req_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::TYPE_W-1:0]          req_type;
  logic signed [deq_pkg::WORD_W-1:0]   value;
  logic [deq_pkg::POS_W-1:0]           position;

  modport source (output valid, output req_type, output value, output position, input ready);
  modport sink (input valid, input req_type, input value, input position, output ready);
endinterface

// File: design/deq_rsp_if.sv
// Response channel: valid/ready handshake carrying one deque result.
`timescale 1ns / 1ps
interface deq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::STATUS_W-1:0]        status;
  logic signed [deq_pkg::WORD_W-1:0]   data;
  logic [deq_pkg::POS_W-1:0]           found_position;
  logic [deq_pkg::COUNT_W-1:0]         count;

  modport source (output valid, output status, output data, output found_position,
                  output count, input ready);
  modport sink (input valid, input status, input data, input found_position,
                input count, output ready);
endinterface

// File: design/deq_cell.sv
// One storage cell of the deque chain: a held word plus one stage of the scan tap line.
`timescale 1ns / 1ps
module deq_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                                clk,
  input  deq_pkg::deq_cell_ctl_t              ctl,
  input  logic [IDX_W-1:0]                    wr_idx,
  input  logic [CNT_W-1:0]                    held,
  input  logic signed [deq_pkg::WORD_W-1:0]   value,
  input  logic signed [deq_pkg::WORD_W-1:0]   left_data,
  input  logic signed [deq_pkg::WORD_W-1:0]   right_data,
  input  logic signed [deq_pkg::WORD_W-1:0]   right_tap_data,
  input  logic                                right_tap_match,
  output logic signed [deq_pkg::WORD_W-1:0]   data,
  output logic signed [deq_pkg::WORD_W-1:0]   tap_data,
  output logic                                tap_match
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  // Held word: shifts with the front end, or takes a direct write.
  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      data <= left_data;
    end else if (ctl.pop_front) begin
      data <= right_data;
    end else if (ctl.wr_en && (wr_idx == MY_IDX)) begin
      data <= value;
    end
  end

  // Tap line: snapshot of the word and its match flag, then moves toward the front.
  always_ff @(posedge clk) begin
    if (ctl.tap_load) begin
      tap_data  <= data;
      tap_match <= (data == value) && (MY_CNT < held);
    end else if (ctl.tap_shift) begin
      tap_data  <= right_tap_data;
      tap_match <= right_tap_match;
    end
  end

endmodule

// File: design/double_ended_queue_core.sv
// Top level of the bounded deque: cell chain, controller and result register.
// Push front, push back, pop front, peek front, update, and any request on an empty deque:
// result in the cycle after the transfer, and one request per cycle while results are taken.
// Pop back, peek back and search on a non-empty deque: a tap line walks the cells toward
// the front until it resolves offset count-1 or the first match, then the result is loaded.
// No request is taken during the walk. Reset (synchronous, active high) empties the deque
// and drops any pending result; stored words are not cleared.
`timescale 1ns / 1ps
module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  deq_req_if.sink    req,
  deq_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (deq_pkg::POS_W > CNT_W) ? deq_pkg::POS_W : CNT_W;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  // Registers.
  state_t                               state;
  logic [CNT_W-1:0]                     held;
  logic [IDX_W-1:0]                     scan_cnt;
  logic                                 scan_search;
  logic                                 scan_pop;
  logic                                 rsp_valid;
  logic [deq_pkg::STATUS_W-1:0]         rsp_status;
  logic signed [deq_pkg::WORD_W-1:0]    rsp_data;
  logic [deq_pkg::POS_W-1:0]            rsp_found;
  logic [deq_pkg::COUNT_W-1:0]          rsp_count;

  // Next values and controls.
  state_t                               state_next;
  logic [CNT_W-1:0]                     held_next;
  logic [IDX_W-1:0]                     scan_cnt_next;
  logic [deq_pkg::STATUS_W-1:0]         status_next;
  logic signed [deq_pkg::WORD_W-1:0]    data_next;
  logic [deq_pkg::POS_W-1:0]            found_next;
  logic                                 rsp_load;
  logic                                 req_fire;
  logic                                 full;
  logic                                 empty;
  logic [CNT_W-1:0]                     held_m1;
  logic                                 scan_last;
  logic                                 pos_ok;
  logic [IDX_W-1:0]                     wr_idx;
  deq_pkg::deq_cell_ctl_t               ctl;

  // Cell chain wiring.
  logic signed [deq_pkg::WORD_W-1:0]    cell_data [DEPTH];
  logic signed [deq_pkg::WORD_W-1:0]    tap_data  [DEPTH];
  logic                                 tap_match [DEPTH];

  // Handshake and status flags.
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign full      = (held == CNT_W'(DEPTH));
  assign empty     = (held == '0);
  assign held_m1   = held - CNT_W'(1);
  assign scan_last = (scan_cnt == IDX_W'(held_m1));
  assign pos_ok    = (CMP_W'(req.position) < CMP_W'(held));

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.data           = rsp_data;
  assign rsp.found_position = rsp_found;
  assign rsp.count          = rsp_count;

  // Request decode and scan control.
  always_comb begin
    ctl           = '0;
    wr_idx        = IDX_W'(held);
    state_next    = state;
    held_next     = held;
    scan_cnt_next = scan_cnt;
    rsp_load      = 1'b0;
    status_next   = deq_pkg::ST_OK;
    data_next     = '0;
    found_next    = '0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          rsp_load = 1'b1;
          unique case (req.req_type) inside
            deq_pkg::REQ_PUSH_FRONT: begin
              if (full) begin
                status_next = deq_pkg::ST_FULL;
              end else begin
                ctl.push_front = 1'b1;
                held_next      = held + CNT_W'(1);
              end
            end
            deq_pkg::REQ_PUSH_BACK: begin
              if (full) begin
                status_next = deq_pkg::ST_FULL;
              end else begin
                ctl.wr_en = 1'b1;
                held_next = held + CNT_W'(1);
              end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
              if (empty) begin
                status_next = deq_pkg::ST_EMPTY;
              end else begin
                data_next = cell_data[0];
                if (req.req_type == deq_pkg::REQ_POP_FRONT) begin
                  ctl.pop_front = 1'b1;
                  held_next     = held_m1;
                end
              end
            end
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
              if (empty) begin
                status_next = deq_pkg::ST_EMPTY;
              end else begin
                rsp_load      = 1'b0;
                ctl.tap_load  = 1'b1;
                scan_cnt_next = '0;
                state_next    = S_SCAN;
              end
            end
            deq_pkg::REQ_SEARCH: begin
              if (empty) begin
                status_next = deq_pkg::ST_NOT_FOUND;
              end else begin
                rsp_load      = 1'b0;
                ctl.tap_load  = 1'b1;
                scan_cnt_next = '0;
                state_next    = S_SCAN;
              end
            end
            deq_pkg::REQ_UPDATE: begin
              if (pos_ok) begin
                ctl.wr_en = 1'b1;
                wr_idx    = IDX_W'(req.position);
              end else begin
                status_next = deq_pkg::ST_BAD_POS;
              end
            end
            default: begin
              status_next = deq_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_search && tap_match[0]) begin
          // First match has reached the front cell.
          rsp_load   = 1'b1;
          found_next = deq_pkg::POS_W'(scan_cnt);
          state_next = S_IDLE;
        end else if (scan_last) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          if (scan_search) begin
            status_next = deq_pkg::ST_NOT_FOUND;
          end else begin
            data_next = tap_data[0];
            if (scan_pop) begin
              held_next = held_m1;
            end
          end
        end else begin
          ctl.tap_shift = 1'b1;
          scan_cnt_next = scan_cnt + IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, occupancy and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      held     <= held_next;
      scan_cnt <= scan_cnt_next;
      if (req_fire) begin
        scan_search <= (req.req_type == deq_pkg::REQ_SEARCH);
        scan_pop    <= (req.req_type == deq_pkg::REQ_POP_BACK);
      end
      if (rsp_load) begin
        rsp_valid  <= 1'b1;
        rsp_status <= status_next;
        rsp_data   <= data_next;
        rsp_found  <= found_next;
        rsp_count  <= deq_pkg::COUNT_W'(held_next);
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Chain of cells; offset zero is always the front entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::WORD_W-1:0] left_w;
    logic signed [deq_pkg::WORD_W-1:0] right_w;
    logic signed [deq_pkg::WORD_W-1:0] right_tap_w;
    logic                              right_match_w;

    if (i == 0) begin : g_first
      assign left_w = req.value;
    end else begin : g_inner_l
      assign left_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w       = '0;
      assign right_tap_w   = '0;
      assign right_match_w = 1'b0;
    end else begin : g_inner_r
      assign right_w       = cell_data[i+1];
      assign right_tap_w   = tap_data[i+1];
      assign right_match_w = tap_match[i+1];
    end

    deq_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk             (clk),
      .ctl             (ctl),
      .wr_idx          (wr_idx),
      .held            (held),
      .value           (req.value),
      .left_data       (left_w),
      .right_data      (right_w),
      .right_tap_data  (right_tap_w),
      .right_tap_match (right_match_w),
      .data            (cell_data[i]),
      .tap_data        (tap_data[i]),
      .tap_match       (tap_match[i])
    );
  end

  // The occupancy never passes the number of cells.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(DEPTH))
    else $error("deque occupancy above depth");

  // A scan only runs over a non-empty deque.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (held != '0))
    else $error("scan running on empty deque");

  // A result is only written into a free or draining result register.
  a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || rsp.ready))
    else $error("result register overwritten");

  // An accepted push on a deque with room grows it by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !full && ((req.req_type == deq_pkg::REQ_PUSH_FRONT) ||
                           (req.req_type == deq_pkg::REQ_PUSH_BACK)))
    |=> (held == $past(held) + CNT_W'(1)))
    else $error("push did not grow the deque");

endmodule

// File: tb/sv/tb_double_ended_queue_core.sv
// Self-checking testbench for the bounded deque core with a mirrored deque model.
`timescale 1ns / 1ps
module tb_double_ended_queue_core;

  localparam int DEPTH = deq_pkg::DEPTH_DEFAULT;
  // The longest stretch without any transfer is a full-depth back access or search
  // plus the longest stall burst on each side, so this is many times that.
  localparam int STALL_LIMIT = 1000;
  // A tap walk over the whole chain bounds how long a result can still be on its way.
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_START = 900;

  typedef struct packed {
    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::WORD_W-1:0]   data;
    logic [deq_pkg::POS_W-1:0]    found_position;
    logic [deq_pkg::COUNT_W-1:0]  count;
  } deq_result_t;

  // Mirror of the deque contents that predicts each result and checks it in order.
  class deque_mirror;
    logic [deq_pkg::WORD_W-1:0] words[DEPTH];
    int front_slot;
    int held;
    deq_result_t awaited[$];
    int errors;

    function new();
      front_slot = 0;
      held = 0;
      errors = 0;
    endfunction

    function int slot_at(int offset);
      return (front_slot + offset) % DEPTH;
    endfunction

    function int held_count();
      return held;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function logic [deq_pkg::WORD_W-1:0] word_at(int offset);
      return words[slot_at(offset)];
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void apply_request(logic [deq_pkg::TYPE_W-1:0] kind,
                                logic [deq_pkg::WORD_W-1:0] word,
                                logic [deq_pkg::POS_W-1:0] pos);
      deq_result_t r;
      int i;
      r = '0;
      r.status = deq_pkg::ST_OK;
      case (kind)
        deq_pkg::REQ_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            r.status = deq_pkg::ST_FULL;
          end else begin
            front_slot = (front_slot + DEPTH - 1) % DEPTH;
            words[front_slot] = word;
            held++;
          end
        end
        deq_pkg::REQ_PUSH_BACK: begin
          if (held >= DEPTH) begin
            r.status = deq_pkg::ST_FULL;
          end else begin
            words[slot_at(held)] = word;
            held++;
          end
        end
        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
          if (held == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            r.data = words[front_slot];
            if (kind == deq_pkg::REQ_POP_FRONT) begin
              front_slot = slot_at(1);
              held--;
            end
          end
        end
        deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
          if (held == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else begin
            r.data = words[slot_at(held - 1)];
            if (kind == deq_pkg::REQ_POP_BACK) held--;
          end
        end
        deq_pkg::REQ_SEARCH: begin
          r.status = deq_pkg::ST_NOT_FOUND;
          for (i = 0; i < held; i++) begin
            if (r.status == deq_pkg::ST_NOT_FOUND && words[slot_at(i)] == word) begin
              r.status = deq_pkg::ST_OK;
              r.found_position = deq_pkg::POS_W'(i);
            end
          end
        end
        default: begin
          if (int'(pos) < held) begin
            words[slot_at(int'(pos))] = word;
          end else begin
            r.status = deq_pkg::ST_BAD_POS;
          end
        end
      endcase
      r.count = deq_pkg::COUNT_W'(held);
      awaited.push_back(r);
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Compare one accepted result with the oldest prediction.
    task compare_result(deq_result_t got);
      deq_result_t want;
      if (awaited.size() == 0) begin
        flag_mismatch("result transfer with no request outstanding");
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.data !== want.data)
        flag_mismatch($sformatf("data %h, expected %h", got.data, want.data));
      if (got.found_position !== want.found_position)
        flag_mismatch($sformatf("found_position %0d, expected %0d",
                                got.found_position, want.found_position));
      if (got.count !== want.count)
        flag_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit quiet;
  int items_sent;
  int stall_cycles;
  deque_mirror mirror;
  deq_result_t seen_result;

  deq_req_if req_ch();
  deq_rsp_if rsp_ch();

  double_ended_queue_core #(.DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Random word with extremes and a small pool of values that repeat.
  function automatic logic [deq_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return deq_pkg::WORD_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom();
    endcase
  endfunction

  // Search key that mostly hits a word the deque holds.
  function automatic logic [deq_pkg::WORD_W-1:0] probe_word();
    if (mirror.held_count() > 0 && $urandom_range(0, 2) != 0)
      return mirror.word_at($urandom_range(0, mirror.held_count() - 1));
    return pick_word();
  endfunction

  // Present one request, possibly after an idle burst, and wait for its transfer.
  task automatic send(logic [deq_pkg::TYPE_W-1:0] kind, logic [deq_pkg::WORD_W-1:0] word,
                      logic [deq_pkg::POS_W-1:0] pos);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value <= word;
    req_ch.position <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    mirror.apply_request(kind, word, pos);
    items_sent++;
  endtask

  // Hold off new requests until every predicted result has been transferred.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror.outstanding() != 0);
  endtask

  // Empty-deque refusals, extreme words, wraparound of the front slot, search and update.
  task automatic run_directed();
    send(deq_pkg::REQ_PEEK_FRONT, 32'h1234_5678, 6'd0);
    send(deq_pkg::REQ_PEEK_BACK, 32'h0, 6'd63);
    send(deq_pkg::REQ_POP_FRONT, 32'h0, 6'd0);
    send(deq_pkg::REQ_POP_BACK, 32'hffff_ffff, 6'd0);
    send(deq_pkg::REQ_SEARCH, 32'h0, 6'd0);
    send(deq_pkg::REQ_UPDATE, 32'h1, 6'd0);
    send(deq_pkg::REQ_UPDATE, 32'h1, 6'd63);
    send(deq_pkg::REQ_PUSH_BACK, 32'h7fff_ffff, 6'd0);
    send(deq_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 6'd0);
    send(deq_pkg::REQ_PUSH_BACK, 32'h0, 6'd0);
    send(deq_pkg::REQ_PUSH_FRONT, 32'hffff_ffff, 6'd0);
    send(deq_pkg::REQ_PEEK_FRONT, 32'h0, 6'd0);
    send(deq_pkg::REQ_PEEK_BACK, 32'h0, 6'd0);
    send(deq_pkg::REQ_SEARCH, 32'h0, 6'd0);
    send(deq_pkg::REQ_SEARCH, 32'h8000_0000, 6'd0);
    send(deq_pkg::REQ_SEARCH, 32'd12345, 6'd0);
    send(deq_pkg::REQ_UPDATE, 32'h5a5a_5a5a, 6'd3);
    send(deq_pkg::REQ_UPDATE, 32'ha5a5_a5a5, 6'd4);
    send(deq_pkg::REQ_UPDATE, 32'ha5a5_a5a5, 6'd63);
    send(deq_pkg::REQ_POP_BACK, 32'h0, 6'd0);
    send(deq_pkg::REQ_POP_FRONT, 32'h0, 6'd0);
    send(deq_pkg::REQ_POP_FRONT, 32'h0, 6'd0);
    send(deq_pkg::REQ_POP_BACK, 32'h0, 6'd0);
    send(deq_pkg::REQ_POP_FRONT, 32'h0, 6'd0);
  endtask

  // Push at random ends until full, then a few refused pushes.
  task automatic fill_up();
    int extra;
    extra = $urandom_range(1, 3);
    while (mirror.held_count() < DEPTH)
      send($urandom_range(0, 1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT,
           pick_word(), deq_pkg::POS_W'($urandom_range(0, 63)));
    repeat (extra)
      send($urandom_range(0, 1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT,
           pick_word(), deq_pkg::POS_W'($urandom_range(0, 63)));
  endtask

  // Pop from random ends until empty, with reads mixed in, then refused requests.
  task automatic drain_out();
    int extra;
    extra = $urandom_range(1, 3);
    while (mirror.held_count() > 0) begin
      case ($urandom_range(0, 5))
        0: send(deq_pkg::REQ_PEEK_FRONT, pick_word(),
                deq_pkg::POS_W'($urandom_range(0, 63)));
        1: send(deq_pkg::REQ_PEEK_BACK, pick_word(),
                deq_pkg::POS_W'($urandom_range(0, 63)));
        2: send(deq_pkg::REQ_SEARCH, probe_word(),
                deq_pkg::POS_W'($urandom_range(0, 63)));
        default: send($urandom_range(0, 1) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT,
                      pick_word(), deq_pkg::POS_W'($urandom_range(0, 63)));
      endcase
    end
    repeat (extra)
      send(deq_pkg::TYPE_W'($urandom_range(2, 7)), pick_word(),
           deq_pkg::POS_W'($urandom_range(0, 63)));
  endtask

  // Any operation, with search keys and update offsets aimed mostly at held entries.
  task automatic mixed_traffic();
    int n;
    logic [deq_pkg::TYPE_W-1:0] kind;
    logic [deq_pkg::POS_W-1:0] pos;
    n = $urandom_range(20, 60);
    repeat (n) begin
      kind = deq_pkg::TYPE_W'($urandom_range(0, 7));
      pos = deq_pkg::POS_W'($urandom_range(0, 63));
      if (kind == deq_pkg::REQ_UPDATE && mirror.held_count() > 0 &&
          $urandom_range(0, 3) != 0)
        pos = deq_pkg::POS_W'($urandom_range(0, mirror.held_count() - 1));
      send(kind, (kind == deq_pkg::REQ_SEARCH) ? probe_word() : pick_word(), pos);
    end
  endtask

  // Result side: random stall bursts unless idling is switched off.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Check every result transfer against the mirror.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen_result.status = rsp_ch.status;
      seen_result.data = rsp_ch.data;
      seen_result.found_position = rsp_ch.found_position;
      seen_result.count = rsp_ch.count;
      mirror.compare_result(seen_result);
    end
  end

  // Watchdog on cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed checks, random phases, then drain and verdict.
  initial begin
    mirror = new();
    quiet = 1'b0;
    items_sent = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= deq_pkg::REQ_PEEK_FRONT;
    req_ch.value <= '0;
    req_ch.position <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    wait_for_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = (items_sent >= TAIL_START) || ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) wait_for_results();
      case ($urandom_range(0, 2))
        0: fill_up();
        1: drain_out();
        default: mixed_traffic();
      endcase
    end
    quiet = 1'b1;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/deq_pkg.sv
design/deq_req_if.sv
design/deq_rsp_if.sv
design/deq_cell.sv
design/double_ended_queue_core.sv
tb/sv/tb_double_ended_queue_core.sv
